// ----- hdl/kau_pkg.sv -----
package kau_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_FEATURES = 32;
    localparam int CL_BITS      = 4;
    localparam int FT_BITS      = 5;
    localparam int FEAT_W       = 16;
    localparam int DIST_W       = 38;
    localparam int SUM_W        = 32;
    localparam int CNT_W        = 17;
    localparam int CHG_W        = 25;
    localparam int ADDR_W       = CL_BITS + FT_BITS;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_UPD   = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    localparam logic [1:0] REG_CLUSTERS  = 2'd0;
    localparam logic [1:0] REG_FEATURES  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST,
        S_MIN,
        S_SUM,
        S_UPD_RD,
        S_UPD_LAT,
        S_UPD_DIV,
        S_UPD_WR,
        S_RD,
        S_OUT
    } state_t;

    function automatic logic [4:0] clamp_k(input logic [4:0] v);
        logic [4:0] r;
        if (v == 5'd0)
            r = 5'd1;
        else if (v > 5'(MAX_CLUSTERS))
            r = 5'(MAX_CLUSTERS);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [5:0] clamp_f(input logic [5:0] v);
        logic [5:0] r;
        if (v == 6'd0)
            r = 6'd1;
        else if (v > 6'(MAX_FEATURES))
            r = 6'(MAX_FEATURES);
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- hdl/kmeans_assign_update_unit.sv -----
// Lloyd k-means engine, one word per item. Load centroid features (mode 0), stream a point
// one feature per word (mode 1), run the centroid update (mode 2) and read centroids back
// (mode 3). Centroids and per-cluster feature sums sit in synchronous memories with one
// read and one write port; each cluster's sum row carries a valid bit, so no clearing pass
// is needed after reset or after an update. Only one word is in work at a time. A mode 0
// word is written straight into the centroid memory. A mode 1 word is accepted, then runs
// the distance pass over the k active clusters of the centroid memory when its feature is
// active; on the last feature the minimum scan and the 32-entry sum row read-modify-write
// follow, then the result goes into the output register. A mode 3 word reads one centroid
// feature. A mode 2 word forms the mean of every active feature of every non-empty cluster
// with the bit-serial 32-step divider and skips empty active clusters.
module kmeans_assign_update_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [24:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [3:0]          cluster_sel,
    input  logic [4:0]          feature_sel,
    input  logic signed [15:0]  feature_value,
    input  logic                last_feature,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          nearest_cluster,
    output logic [37:0]         distance_sq,
    output logic signed [15:0]  read_value,
    output logic [24:0]         change_total,
    output logic                converged
);

    kau_pkg::state_t state_reg, state_next;

    logic [4:0]  clusters_reg;
    logic [5:0]  features_reg;
    logic [24:0] tolerance_reg;
    logic [4:0]  k_act;
    logic [5:0]  nf_act;

    logic [15:0] cent_mem [kau_pkg::MAX_CLUSTERS * kau_pkg::MAX_FEATURES];
    logic [31:0] sum_mem  [kau_pkg::MAX_CLUSTERS * kau_pkg::MAX_FEATURES];
    logic [15:0] pb_mem   [kau_pkg::MAX_FEATURES];
    logic [15:0] cent_rd_reg;
    logic [31:0] sum_rd_reg;
    logic [15:0] pb_rd_reg;

    logic [37:0] acc_reg   [kau_pkg::MAX_CLUSTERS];
    logic [16:0] count_reg [kau_pkg::MAX_CLUSTERS];
    logic [15:0] row_valid_reg;

    logic [4:0]  fs_reg;
    logic [15:0] val_reg;
    logic        last_reg;

    logic [4:0]  issue_c_reg;
    logic        p1_v_reg, p2_v_reg;
    logic [3:0]  p1_c_reg, p2_c_reg;
    logic [33:0] prod_reg;

    logic [3:0]  mc_reg;
    logic [3:0]  best_reg;
    logic [37:0] bestd_reg;

    logic [5:0]  sf_reg;
    logic        s1_v_reg;
    logic [4:0]  s1_f_reg;

    logic [4:0]  uc_reg;
    logic [5:0]  uf_reg;
    logic [15:0] cent_hold_reg;
    logic [31:0] dq_reg;
    logic [16:0] drem_reg;
    logic        dneg_reg;
    logic [4:0]  dcnt_reg;
    logic [24:0] change_reg;

    logic [3:0]  res_nearest_reg;
    logic [37:0] res_dist_reg;
    logic [15:0] res_read_reg;
    logic [24:0] res_change_reg;
    logic        res_conv_reg;

    logic        out_valid_reg;
    logic [3:0]  out_nearest_reg;
    logic [37:0] out_dist_reg;
    logic [15:0] out_read_reg;
    logic [24:0] out_change_reg;
    logic        out_conv_reg;

    logic        accept;
    logic        fs_active;
    logic        dist_issue, dist_done;
    logic        sum_issue, sum_done;
    logic        min_last, min_take;
    logic [3:0]  min_best;
    logic [37:0] min_bestd;
    logic        upd_end, upd_skip, upd_row_end;
    logic        out_load;

    logic [kau_pkg::ADDR_W-1:0] cent_raddr, cent_waddr, sum_raddr, sum_waddr;
    logic        cent_we;
    logic [15:0] cent_wdata;
    logic        sum_we;
    logic [31:0] sum_wdata;
    logic        pb_we;

    logic signed [16:0] dist_diff;
    logic [16:0] dist_abs;
    logic [38:0] acc_sum;
    logic [37:0] acc_sat;

    logic [31:0] sum_base;
    logic [32:0] sum_ext;
    logic [31:0] sum_sat;

    logic [16:0] div_den;
    logic [18:0] div_sh, div_trial;

    logic [31:0] neg_q;
    logic [15:0] mean16;
    logic [16:0] mean_diff, mean_abs;
    logic [25:0] chg_sum;
    logic [24:0] chg_sat;

    assign k_act     = kau_pkg::clamp_k(clusters_reg);
    assign nf_act    = kau_pkg::clamp_f(features_reg);
    assign accept    = in_valid && !in_stall;
    assign fs_active = {1'b0, feature_sel} < nf_act;

    assign dist_issue = (state_reg == kau_pkg::S_DIST) && (issue_c_reg < k_act);
    assign dist_done  = (issue_c_reg == k_act) && !p1_v_reg && !p2_v_reg;
    assign sum_issue  = (state_reg == kau_pkg::S_SUM) && !sf_reg[5];
    assign sum_done   = sf_reg[5] && !s1_v_reg;

    assign min_last  = ({1'b0, mc_reg} == (k_act - 5'd1));
    assign min_take  = (mc_reg == 4'd0) || (acc_reg[mc_reg] < bestd_reg);
    assign min_best  = min_take ? mc_reg : best_reg;
    assign min_bestd = min_take ? acc_reg[mc_reg] : bestd_reg;

    assign upd_end     = (uc_reg == k_act);
    assign upd_skip    = (count_reg[uc_reg[3:0]] == 17'd0);
    assign upd_row_end = ((uf_reg + 6'd1) == nf_act);

    assign out_load = (state_reg == kau_pkg::S_OUT) && (!out_valid_reg || !out_stall);

    // Distance datapath: |point - centroid| squared, saturating accumulate
    assign dist_diff = $signed({val_reg[15], val_reg}) - $signed({cent_rd_reg[15], cent_rd_reg});
    assign dist_abs  = dist_diff[16] ? 17'(-dist_diff) : 17'(dist_diff);
    assign acc_sum   = {5'd0, prod_reg} + {1'b0, acc_reg[p2_c_reg]};
    assign acc_sat   = acc_sum[38] ? {38{1'b1}} : acc_sum[37:0];

    // Sum row update: rows not valid read as zero
    assign sum_base = row_valid_reg[best_reg] ? sum_rd_reg : 32'd0;
    assign sum_ext  = {sum_base[31], sum_base} + {{17{pb_rd_reg[15]}}, pb_rd_reg};
    always_comb
    begin
        if (sum_ext[32] != sum_ext[31])
            sum_sat = sum_ext[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            sum_sat = sum_ext[31:0];
    end

    // Restoring divider step, one quotient bit per cycle
    assign div_den   = count_reg[uc_reg[3:0]];
    assign div_sh    = {1'b0, drem_reg, dq_reg[31]};
    assign div_trial = div_sh - {2'b00, div_den};

    // Mean clamp and L1 movement
    assign neg_q = 32'(~dq_reg + 32'd1);
    always_comb
    begin
        if (!dneg_reg)
            mean16 = (dq_reg > 32'd32767) ? 16'h7FFF : dq_reg[15:0];
        else
            mean16 = (dq_reg > 32'd32768) ? 16'h8000 : neg_q[15:0];
    end
    assign mean_diff = {mean16[15], mean16} - {cent_hold_reg[15], cent_hold_reg};
    assign mean_abs  = mean_diff[16] ? 17'(-mean_diff) : mean_diff;
    assign chg_sum   = {1'b0, change_reg} + {9'd0, mean_abs};
    assign chg_sat   = chg_sum[25] ? {25{1'b1}} : chg_sum[24:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kau_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        kau_pkg::MODE_LOAD:  state_next = kau_pkg::S_IDLE;
                        kau_pkg::MODE_POINT:
                        begin
                            if (fs_active)
                                state_next = kau_pkg::S_DIST;
                            else if (last_feature)
                                state_next = kau_pkg::S_MIN;
                            else
                                state_next = kau_pkg::S_IDLE;
                        end
                        kau_pkg::MODE_UPD:   state_next = kau_pkg::S_UPD_RD;
                        kau_pkg::MODE_READ:  state_next = kau_pkg::S_RD;
                        default:             state_next = kau_pkg::S_IDLE;
                    endcase
                end
            end
            kau_pkg::S_DIST:
            begin
                if (dist_done)
                    state_next = last_reg ? kau_pkg::S_MIN : kau_pkg::S_IDLE;
            end
            kau_pkg::S_MIN:
            begin
                if (min_last)
                    state_next = kau_pkg::S_SUM;
            end
            kau_pkg::S_SUM:
            begin
                if (sum_done)
                    state_next = kau_pkg::S_OUT;
            end
            kau_pkg::S_UPD_RD:
            begin
                if (upd_end)
                    state_next = kau_pkg::S_OUT;
                else if (!upd_skip)
                    state_next = kau_pkg::S_UPD_LAT;
            end
            kau_pkg::S_UPD_LAT: state_next = kau_pkg::S_UPD_DIV;
            kau_pkg::S_UPD_DIV:
            begin
                if (dcnt_reg == 5'd31)
                    state_next = kau_pkg::S_UPD_WR;
            end
            kau_pkg::S_UPD_WR:  state_next = kau_pkg::S_UPD_RD;
            kau_pkg::S_RD:      state_next = kau_pkg::S_OUT;
            kau_pkg::S_OUT:
            begin
                if (out_load)
                    state_next = kau_pkg::S_IDLE;
            end
            default:            state_next = kau_pkg::S_IDLE;
        endcase
    end

    // Memory port control
    always_comb
    begin
        in_stall   = (state_reg != kau_pkg::S_IDLE);
        cent_we    = 1'b0;
        cent_waddr = {cluster_sel, feature_sel};
        cent_wdata = feature_value;
        cent_raddr = {cluster_sel, feature_sel};
        sum_raddr  = {uc_reg[3:0], uf_reg[4:0]};
        sum_we     = 1'b0;
        sum_waddr  = {best_reg, s1_f_reg};
        sum_wdata  = 32'd0;
        pb_we      = 1'b0;
        unique case (state_reg)
            kau_pkg::S_IDLE:
            begin
                cent_we = accept && (mode == kau_pkg::MODE_LOAD);
                pb_we   = accept && (mode == kau_pkg::MODE_POINT) && fs_active;
            end
            kau_pkg::S_DIST:
            begin
                cent_raddr = {issue_c_reg[3:0], fs_reg};
            end
            kau_pkg::S_SUM:
            begin
                sum_raddr = {best_reg, sf_reg[4:0]};
                sum_we    = s1_v_reg;
                if ({1'b0, s1_f_reg} < nf_act)
                    sum_wdata = sum_sat;
                else
                    sum_wdata = sum_base;
            end
            kau_pkg::S_UPD_RD:
            begin
                cent_raddr = {uc_reg[3:0], uf_reg[4:0]};
            end
            kau_pkg::S_UPD_WR:
            begin
                cent_we    = 1'b1;
                cent_waddr = {uc_reg[3:0], uf_reg[4:0]};
                cent_wdata = mean16;
            end
            default:
            begin
                cent_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cent_we)
            cent_mem[cent_waddr] <= cent_wdata;
        cent_rd_reg <= cent_mem[cent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_rd_reg <= sum_mem[sum_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pb_we)
            pb_mem[feature_sel] <= feature_value;
        pb_rd_reg <= pb_mem[sf_reg[4:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kau_pkg::S_IDLE;
            clusters_reg  <= 5'd1;
            features_reg  <= 6'd1;
            tolerance_reg <= 25'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    kau_pkg::REG_CLUSTERS:  clusters_reg  <= cfg_data[4:0];
                    kau_pkg::REG_FEATURES:  features_reg  <= cfg_data[5:0];
                    kau_pkg::REG_TOLERANCE: tolerance_reg <= cfg_data;
                    default:                clusters_reg  <= clusters_reg;
                endcase
            end
        end
    end

    // Accumulators, counts and row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kau_pkg::MAX_CLUSTERS; i++)
            begin
                acc_reg[i]   <= 38'd0;
                count_reg[i] <= 17'd0;
            end
            row_valid_reg <= 16'd0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
        end
        else
        begin
            p1_v_reg <= dist_issue;
            p2_v_reg <= p1_v_reg;
            s1_v_reg <= sum_issue;
            if (p2_v_reg)
                acc_reg[p2_c_reg] <= acc_sat;
            if ((state_reg == kau_pkg::S_SUM) && sum_done)
            begin
                for (int i = 0; i < kau_pkg::MAX_CLUSTERS; i++)
                    acc_reg[i] <= 38'd0;
                row_valid_reg[best_reg] <= 1'b1;
                if (count_reg[best_reg] != {17{1'b1}})
                    count_reg[best_reg] <= count_reg[best_reg] + 17'd1;
            end
            if ((state_reg == kau_pkg::S_UPD_RD) && upd_end)
            begin
                for (int i = 0; i < kau_pkg::MAX_CLUSTERS; i++)
                    count_reg[i] <= 17'd0;
                row_valid_reg <= 16'd0;
            end
        end
    end

    // Sequencer datapath registers
    always_ff @(posedge clk)
    begin
        p1_c_reg <= issue_c_reg[3:0];
        p2_c_reg <= p1_c_reg;
        prod_reg <= dist_abs * dist_abs;
        s1_f_reg <= sf_reg[4:0];
        unique case (state_reg)
            kau_pkg::S_IDLE:
            begin
                fs_reg      <= feature_sel;
                val_reg     <= feature_value;
                last_reg    <= last_feature;
                issue_c_reg <= 5'd0;
                mc_reg      <= 4'd0;
                best_reg    <= 4'd0;
                bestd_reg   <= 38'd0;
                sf_reg      <= 6'd0;
                uc_reg      <= 5'd0;
                uf_reg      <= 6'd0;
                change_reg  <= 25'd0;
            end
            kau_pkg::S_DIST:
            begin
                if (dist_issue)
                    issue_c_reg <= issue_c_reg + 5'd1;
            end
            kau_pkg::S_MIN:
            begin
                best_reg  <= min_best;
                bestd_reg <= min_bestd;
                mc_reg    <= mc_reg + 4'd1;
            end
            kau_pkg::S_SUM:
            begin
                if (sum_issue)
                    sf_reg <= sf_reg + 6'd1;
                if (sum_done)
                begin
                    res_nearest_reg <= best_reg;
                    res_dist_reg    <= bestd_reg;
                    res_read_reg    <= 16'd0;
                    res_change_reg  <= 25'd0;
                    res_conv_reg    <= 1'b0;
                end
            end
            kau_pkg::S_UPD_RD:
            begin
                if (upd_end)
                begin
                    res_nearest_reg <= 4'd0;
                    res_dist_reg    <= 38'd0;
                    res_read_reg    <= 16'd0;
                    res_change_reg  <= change_reg;
                    res_conv_reg    <= (change_reg <= tolerance_reg);
                end
                else if (upd_skip)
                    uc_reg <= uc_reg + 5'd1;
            end
            kau_pkg::S_UPD_LAT:
            begin
                cent_hold_reg <= cent_rd_reg;
                dneg_reg      <= sum_rd_reg[31];
                dq_reg        <= sum_rd_reg[31] ? 32'(~sum_rd_reg + 32'd1) : sum_rd_reg;
                drem_reg      <= 17'd0;
                dcnt_reg      <= 5'd0;
            end
            kau_pkg::S_UPD_DIV:
            begin
                dcnt_reg <= dcnt_reg + 5'd1;
                if (!div_trial[18])
                begin
                    drem_reg <= div_trial[16:0];
                    dq_reg   <= {dq_reg[30:0], 1'b1};
                end
                else
                begin
                    drem_reg <= div_sh[16:0];
                    dq_reg   <= {dq_reg[30:0], 1'b0};
                end
            end
            kau_pkg::S_UPD_WR:
            begin
                change_reg <= chg_sat;
                if (upd_row_end)
                begin
                    uf_reg <= 6'd0;
                    uc_reg <= uc_reg + 5'd1;
                end
                else
                    uf_reg <= uf_reg + 6'd1;
            end
            kau_pkg::S_RD:
            begin
                res_nearest_reg <= 4'd0;
                res_dist_reg    <= 38'd0;
                res_read_reg    <= cent_rd_reg;
                res_change_reg  <= 25'd0;
                res_conv_reg    <= 1'b0;
            end
            default:
            begin
                issue_c_reg <= issue_c_reg;
            end
        endcase
    end

    // Output register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_nearest_reg <= res_nearest_reg;
            out_dist_reg    <= res_dist_reg;
            out_read_reg    <= res_read_reg;
            out_change_reg  <= res_change_reg;
            out_conv_reg    <= res_conv_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign nearest_cluster = out_nearest_reg;
    assign distance_sq     = out_dist_reg;
    assign read_value      = out_read_reg;
    assign change_total    = out_change_reg;
    assign converged       = out_conv_reg;

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == kau_pkg::S_OUT)
        else $error("result word loaded outside output state");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kau_pkg::S_UPD_DIV) |-> (div_den != 17'd0))
        else $error("mean division by empty cluster");

    a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        p2_v_reg |-> ({1'b0, p2_c_reg} < k_act))
        else $error("distance write beyond active clusters");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != kau_pkg::S_IDLE) |-> in_stall)
        else $error("word accepted while sequencer busy");

endmodule
